// File: sv/line_sensor_capture_sequencer_defines.svh
// Assertion macros shared by the capture sequencer RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef LINE_SENSOR_CAPTURE_SEQUENCER_DEFINES_SVH
`define LINE_SENSOR_CAPTURE_SEQUENCER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define LSCS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the cycle after.
`define LSCS_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/lscs_pkg.sv
// Package for the line sensor capture sequencer: sizes, command and phase codes,
// and the result record. No dependencies.
`timescale 1ns / 1ps

package lscs_pkg;

	localparam int PIXELS  = 128;
	localparam int BUFFERS = 2;
	localparam int PIX_AW  = $clog2(PIXELS);
	localparam int RAM_AW  = PIX_AW + 1;
	localparam int RAM_D   = BUFFERS << PIX_AW;
	localparam int NCNT    = 5;

	localparam logic [7:0] PIXELS_C = 8'(PIXELS);

	typedef enum logic [2:0] {
		CMD_START  = 3'd0,
		CMD_STOP   = 3'd1,
		CMD_TICK   = 3'd2,
		CMD_EDGE   = 3'd3,
		CMD_SAMPLE = 3'd4,
		CMD_TAKE   = 3'd5,
		CMD_RDPIX  = 3'd6,
		CMD_RDCNT  = 3'd7
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'b0001,
		PH_WAIT_HIGH = 4'b0010,
		PH_WAIT_LOW  = 4'b0100,
		PH_CAPTURE   = 4'b1000
	} phase_t;

	localparam logic [2:0] CNT_REQ    = 3'd0;
	localparam logic [2:0] CNT_PULSE  = 3'd1;
	localparam logic [2:0] CNT_DONE   = 3'd2;
	localparam logic [2:0] CNT_DROP   = 3'd3;
	localparam logic [2:0] CNT_SAMPLE = 3'd4;

	localparam logic [2:0] REG_FRAME_INTERVAL = 3'd0;

	typedef struct packed {
		logic        accepted;
		logic        shutter_level;
		logic        convert_request;
		logic        timer_restart;
		logic        frame_done;
		logic        buffer_index;
		logic        streaming;
		logic        is_pix;
		logic [31:0] counter_value;
	} res_t;

endpackage

// File: sv/lscs_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lscs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/line_sensor_capture_sequencer.sv
// Top level of the line sensor capture sequencer: command decode, control state,
// counters, output staging. Depends on lscs_pkg, lscs_ram and the defines header.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    command, sample, buffer_select,
//                                           pixel_index, counter_select
// output    out        out_valid/out_ready  accepted .. counter_value
// config    in         APB psel/penable     frame_interval at address 0
//
// One transaction is accepted per cycle while in_ready is high; its result goes to s1_q
// and then to out_q, which offers it. The pixel memory read data is registered with s1_q.
// Reset clears all control state and counters; the pixel memory is not cleared.
// A stalled output holds up to two results before in_ready falls.
`timescale 1ns / 1ps
`include "line_sensor_capture_sequencer_defines.svh"

module line_sensor_capture_sequencer
	import lscs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [15:0] sample,
	input  logic        buffer_select,
	input  logic [6:0]  pixel_index,
	input  logic [2:0]  counter_select,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic        shutter_level,
	output logic        convert_request,
	output logic        clock_running,
	output logic        timer_restart,
	output logic        frame_done,
	output logic        buffer_index,
	output logic [15:0] pixel_value,
	output logic        streaming,
	output logic [31:0] counter_value
);

	logic [31:0] interval_q;
	phase_t      phase_q, phase_n;
	logic        stream_q, stream_n;
	logic [7:0]  pos_q, pos_n;
	logic        whalf_q, whalf_n;
	logic        rhalf_q, rhalf_n;
	logic        rdy_q, rdy_n;
	logic        pend_q, pend_n;
	logic        shut_q, shut_n;
	logic [31:0] cnt_q [NCNT];
	logic [NCNT-1:0] cnt_inc;
	logic        cnt_clr;

	res_t        res;
	res_t        s1_q;
	logic        s1_vld_q;
	res_t        out_q;
	logic [15:0] pix_q;
	logic        out_vld_q;
	logic        s1_adv;
	logic        in_acc;
	logic        wr_en, rd_en;
	logic [RAM_AW-1:0] waddr, raddr;
	logic [15:0] rdata;
	cmd_t        cmd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAME_INTERVAL[0]) ? interval_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_FRAME_INTERVAL[0]) begin
			interval_q <= pwdata;
		end
	end

	assign s1_adv   = s1_vld_q && (!out_vld_q || out_ready);
	assign in_ready = !s1_vld_q || s1_adv;
	assign in_acc   = in_valid && in_ready;
	assign cmd      = cmd_t'(command);

	always_comb begin
		phase_n  = phase_q;
		stream_n = stream_q;
		pos_n    = pos_q;
		whalf_n  = whalf_q;
		rhalf_n  = rhalf_q;
		rdy_n    = rdy_q;
		pend_n   = pend_q;
		shut_n   = shut_q;
		cnt_inc  = '0;
		cnt_clr  = 1'b0;
		res      = '0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		unique case (cmd)
			CMD_START: begin
				if (!stream_q) begin
					cnt_clr  = 1'b1;
					rdy_n    = 1'b0;
					rhalf_n  = 1'b0;
					whalf_n  = 1'b0;
					pend_n   = 1'b0;
					pos_n    = '0;
					stream_n = 1'b1;
					if (interval_q == 32'd0) begin
						phase_n = PH_WAIT_HIGH;
					end else begin
						phase_n = PH_IDLE;
						res.timer_restart = 1'b1;
					end
					res.accepted = 1'b1;
				end
			end
			CMD_STOP: begin
				stream_n = 1'b0;
				shut_n   = 1'b0;
				phase_n  = PH_IDLE;
				pend_n   = 1'b0;
				pos_n    = '0;
				rdy_n    = 1'b0;
				rhalf_n  = 1'b0;
				whalf_n  = 1'b0;
			end
			CMD_TICK: begin
				if (stream_q) begin
					cnt_inc[CNT_REQ] = 1'b1;
					if (phase_q == PH_IDLE) begin
						phase_n = PH_WAIT_HIGH;
						pos_n   = '0;
					end else begin
						pend_n = 1'b1;
					end
					res.timer_restart = (interval_q != 32'd0);
				end
			end
			CMD_EDGE: begin
				if (stream_q) begin
					unique case (phase_q)
						PH_WAIT_HIGH: begin
							shut_n  = 1'b1;
							phase_n = PH_WAIT_LOW;
						end
						PH_WAIT_LOW: begin
							shut_n  = 1'b0;
							cnt_inc[CNT_PULSE] = 1'b1;
							phase_n = PH_CAPTURE;
						end
						PH_CAPTURE: begin
							if (pos_q < PIXELS_C) begin
								res.convert_request = 1'b1;
							end else begin
								res.frame_done = 1'b1;
								cnt_inc[CNT_DROP] = rdy_q;
								cnt_inc[CNT_DONE] = 1'b1;
								rhalf_n = whalf_q;
								rdy_n   = 1'b1;
								whalf_n = ~whalf_q;
								pend_n  = 1'b0;
								phase_n = PH_IDLE;
								pos_n   = '0;
								if (interval_q == 32'd0) begin
									phase_n = PH_WAIT_HIGH;
								end else if (pend_q) begin
									phase_n = PH_WAIT_HIGH;
									res.timer_restart = 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			CMD_SAMPLE: begin
				if (stream_q) begin
					cnt_inc[CNT_SAMPLE] = 1'b1;
					if (phase_q == PH_CAPTURE && pos_q < PIXELS_C) begin
						wr_en = 1'b1;
						pos_n = pos_q + 8'd1;
					end
				end
			end
			CMD_TAKE: begin
				if (rdy_q) begin
					res.accepted     = 1'b1;
					res.buffer_index = rhalf_q;
					rdy_n            = 1'b0;
				end
			end
			CMD_RDPIX: begin
				if ({1'b0, pixel_index} < PIXELS_C) begin
					rd_en      = 1'b1;
					res.is_pix = 1'b1;
				end
			end
			CMD_RDCNT: begin
				unique case (counter_select)
					CNT_REQ:    res.counter_value = cnt_q[CNT_REQ];
					CNT_PULSE:  res.counter_value = cnt_q[CNT_PULSE];
					CNT_DONE:   res.counter_value = cnt_q[CNT_DONE];
					CNT_DROP:   res.counter_value = cnt_q[CNT_DROP];
					CNT_SAMPLE: res.counter_value = cnt_q[CNT_SAMPLE];
					default:    res.counter_value = 32'd0;
				endcase
			end
			default: begin
			end
		endcase
		res.shutter_level = shut_n;
		res.streaming     = stream_n;
	end

	assign waddr = {whalf_q, pos_q[PIX_AW-1:0]};
	assign raddr = {buffer_select, PIX_AW'(pixel_index)};

	lscs_ram #(
		.WIDTH(16),
		.DEPTH(RAM_D)
	) u_pix_ram (
		.clk  (clk),
		.we   (in_acc && wr_en),
		.waddr(waddr),
		.wdata(sample),
		.re   (in_acc && rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			stream_q <= 1'b0;
			pos_q    <= '0;
			whalf_q  <= 1'b0;
			rhalf_q  <= 1'b0;
			rdy_q    <= 1'b0;
			pend_q   <= 1'b0;
			shut_q   <= 1'b0;
		end else if (in_acc) begin
			phase_q  <= phase_n;
			stream_q <= stream_n;
			pos_q    <= pos_n;
			whalf_q  <= whalf_n;
			rhalf_q  <= rhalf_n;
			rdy_q    <= rdy_n;
			pend_q   <= pend_n;
			shut_q   <= shut_n;
		end
	end

	for (genvar i = 0; i < NCNT; i++) begin : g_cnt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[i] <= '0;
			end else if (in_acc) begin
				if (cnt_clr) begin
					cnt_q[i] <= '0;
				end else if (cnt_inc[i]) begin
					cnt_q[i] <= cnt_q[i] + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_vld_q <= 1'b1;
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_adv) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_q <= res;
		end
		if (s1_adv) begin
			out_q <= s1_q;
			pix_q <= s1_q.is_pix ? rdata : 16'd0;
		end
	end

	assign out_valid       = out_vld_q;
	assign accepted        = out_q.accepted;
	assign shutter_level   = out_q.shutter_level;
	assign convert_request = out_q.convert_request;
	assign clock_running   = out_q.streaming;
	assign timer_restart   = out_q.timer_restart;
	assign frame_done      = out_q.frame_done;
	assign buffer_index    = out_q.buffer_index;
	assign pixel_value     = pix_q;
	assign streaming       = out_q.streaming;
	assign counter_value   = out_q.counter_value;

	`LSCS_ASSERT_ALWAYS(a_shutter_phase, !shut_q || phase_q == PH_WAIT_LOW, "shutter high outside pulse")
	`LSCS_ASSERT_ALWAYS(a_idle_clean, stream_q || (phase_q == PH_IDLE && !pend_q), "idle with active phase")
	`LSCS_ASSERT_ALWAYS(a_pos_range, pos_q <= PIXELS_C, "pixel position past line end")
	`LSCS_ASSERT_NEXT(a_stage_hold, s1_vld_q && !s1_adv, s1_vld_q && $stable(s1_q), "stage lost a result")

endmodule
